### rtl/msd_pkg.sv
`timescale 1ns / 1ps
package msd_pkg;

	localparam int unsigned HDR_BYTES       = 8;
	localparam int unsigned LEN_FIRST       = 4;
	localparam int unsigned COUNT_SAT       = 9;
	localparam int unsigned MSD_QUEUE_DEPTH = 4;

	localparam logic [7:0] TYPE_OUT = 8'd1;
	localparam logic [7:0] TYPE_ERR = 8'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SHORT   = 2'd1;
	localparam logic [1:0] ST_TRUNC   = 2'd2;
	localparam logic [1:0] ST_OVERRUN = 2'd3;

	// one queued job: an optional payload beat and an optional end status
	typedef struct packed {
		logic       has_pay;
		logic [7:0] pay;
		logic       ch;
		logic       last;
		logic [1:0] status;
	} cmd_t;

endpackage

### rtl/msd_front.sv
`timescale 1ns / 1ps
module msd_front import msd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	input  logic       last,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic        in_payload_q;
	logic [2:0]  hdr_idx_q;
	logic [7:0]  ftype_q;
	logic [31:0] rem_q;
	logic [3:0]  bcount_q;

	logic        in_payload_nx;
	logic [2:0]  hdr_idx_nx;
	logic [7:0]  ftype_nx;
	logic [31:0] rem_nx;
	logic [3:0]  bcount_nx;
	logic        accept;

	assign data_ready = !q_full;
	assign accept     = data_valid && data_ready;

	always_comb begin
		in_payload_nx = in_payload_q;
		hdr_idx_nx    = hdr_idx_q;
		ftype_nx      = ftype_q;
		rem_nx        = rem_q;
		bcount_nx     = (bcount_q < 4'(COUNT_SAT)) ? bcount_q + 4'd1 : bcount_q;
		q_cmd.has_pay = 1'b0;
		q_cmd.pay     = data_byte;
		q_cmd.ch      = (ftype_q == TYPE_ERR);
		q_cmd.last    = last;

		if (!in_payload_q) begin
			if (hdr_idx_q == 3'd0) begin
				ftype_nx = data_byte;
				rem_nx   = '0;
			end else if (hdr_idx_q >= 3'(LEN_FIRST)) begin
				rem_nx = {rem_q[23:0], data_byte};
			end
			if (hdr_idx_q == 3'(HDR_BYTES - 1)) begin
				hdr_idx_nx    = 3'd0;
				in_payload_nx = (rem_nx != 32'd0);
			end else begin
				hdr_idx_nx = hdr_idx_q + 3'd1;
			end
		end else begin
			q_cmd.has_pay = (ftype_q == TYPE_OUT) || (ftype_q == TYPE_ERR);
			rem_nx        = rem_q - 32'd1;
			in_payload_nx = (rem_nx != 32'd0);
		end

		if (bcount_nx <= 4'(HDR_BYTES))
			q_cmd.status = ST_SHORT;
		else if (!in_payload_nx && hdr_idx_nx != 3'd0)
			q_cmd.status = ST_TRUNC;
		else if (in_payload_nx)
			q_cmd.status = ST_OVERRUN;
		else
			q_cmd.status = ST_OK;
	end

	assign q_push = accept && (q_cmd.has_pay || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hdr_idx_q    <= '0;
			ftype_q      <= '0;
			rem_q        <= '0;
			bcount_q     <= '0;
		end else if (accept) begin
			if (last) begin
				// stream ends: start over on the next beat
				in_payload_q <= 1'b0;
				hdr_idx_q    <= '0;
				ftype_q      <= '0;
				rem_q        <= '0;
				bcount_q     <= '0;
			end else begin
				in_payload_q <= in_payload_nx;
				hdr_idx_q    <= hdr_idx_nx;
				ftype_q      <= ftype_nx;
				rem_q        <= rem_nx;
				bcount_q     <= bcount_nx;
			end
		end
	end

endmodule

### rtl/msd_fifo.sv
`timescale 1ns / 1ps
module msd_fifo import msd_pkg::*; #(
	parameter int unsigned DEPTH = MSD_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;

	assign full  = (count_q == (AW+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + (AW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (AW+1)'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

### rtl/msd_back.sv
`timescale 1ns / 1ps
module msd_back import msd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       q_cmd,
	input  logic       q_empty,
	output logic       q_pop,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] payload_byte,
	output logic       channel,
	output logic       is_status,
	output logic [1:0] status,
	output logic       end_of_run
);

	logic       out_valid_q;
	logic [7:0] pay_q;
	logic       ch_q;
	logic       is_st_q;
	logic [1:0] st_q;
	logic       eor_q;
	logic       st_pend_q;
	logic [1:0] pend_st_q;
	logic       load;

	assign load  = !out_valid_q || result_ready;
	assign q_pop = load && !st_pend_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			st_pend_q   <= 1'b0;
		end else if (load) begin
			if (st_pend_q) begin
				out_valid_q <= 1'b1;
				st_pend_q   <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				// payload first, status follows on the next beat
				st_pend_q   <= q_cmd.has_pay && q_cmd.last;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (st_pend_q) begin
				pay_q   <= '0;
				ch_q    <= 1'b0;
				is_st_q <= 1'b1;
				st_q    <= pend_st_q;
				eor_q   <= 1'b1;
			end else if (!q_empty) begin
				pend_st_q <= q_cmd.status;
				if (q_cmd.has_pay) begin
					pay_q   <= q_cmd.pay;
					ch_q    <= q_cmd.ch;
					is_st_q <= 1'b0;
					st_q    <= ST_OK;
					eor_q   <= !q_cmd.last;
				end else begin
					pay_q   <= '0;
					ch_q    <= 1'b0;
					is_st_q <= 1'b1;
					st_q    <= q_cmd.status;
					eor_q   <= 1'b1;
				end
			end
		end
	end

	assign result_valid = out_valid_q;
	assign payload_byte = pay_q;
	assign channel      = ch_q;
	assign is_status    = is_st_q;
	assign status       = st_q;
	assign end_of_run   = eor_q;

`ifndef NO_ASSERTIONS
	a_pend_behind_payload: assert property (@(posedge clk) disable iff (!arst_n)
		st_pend_q |-> (out_valid_q && !is_st_q && !eor_q))
		else $error("pending status without a payload beat ahead of it");
	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_st_q) |-> eor_q)
		else $error("status beat not marked end of run");
`endif

endmodule

### rtl/multiplexed_stream_demux.sv
`timescale 1ns / 1ps
// Multiplexed stream demultiplexer.
// Input channel (data_valid/data_ready): one stream byte per beat, last marks
// the final byte. Frames are an 8-byte header (byte 0 type, bytes 4..7
// big-endian length) and then the payload.
// Output channel (result_valid/result_ready): payload bytes of type 1 frames
// on channel 0, of type 2 frames on channel 1; other types are dropped. The
// last byte adds one status beat (is_status set) after any payload beat.
// Throughput: one input byte per cycle while the queue is not full. A last
// byte that carries payload takes a payload beat and a status beat on the
// output; the command queue absorbs that. An accepted byte's result is
// written to the queue, then loaded into the output register.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and data_ready drops once QUEUE_DEPTH commands wait. Header bytes
// and skipped payload need no queue space unless they are the last byte.
// Reset clears the header parser, the queue and the output valid flag; the
// block is ready for a new stream as soon as reset is released.
module multiplexed_stream_demux import msd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = MSD_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	input  logic       last,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [7:0] payload_byte,
	output logic       channel,
	output logic       is_status,
	output logic [1:0] status,
	output logic       end_of_run
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	cmd_t q_wcmd;
	cmd_t q_rcmd;

	msd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data_byte  (data_byte),
		.last       (last),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_wcmd)
	);

	msd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wcmd),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rcmd),
		.empty  (q_empty)
	);

	msd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_cmd        (q_rcmd),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.payload_byte (payload_byte),
		.channel      (channel),
		.is_status    (is_status),
		.status       (status),
		.end_of_run   (end_of_run)
	);

endmodule

### bench/tb_multiplexed_stream_demux.sv
`timescale 1ns / 1ps
module tb_multiplexed_stream_demux import msd_pkg::*; ();

	typedef struct {
		logic [7:0] payload;
		logic       ch;
		logic       is_st;
		logic [1:0] st;
		logic       eor;
	} demux_beat_t;

	class demux_scoreboard;
		logic        in_pay;
		logic [2:0]  hdr_pos;
		logic [7:0]  ftype;
		logic [31:0] remaining;
		logic [3:0]  seen;
		demux_beat_t expected_beats[$];
		int          errors;
		int          n_payload;
		int          n_status[4];

		function new();
			errors = 0;
			n_payload = 0;
			foreach (n_status[i]) n_status[i] = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			in_pay = 1'b0;
			hdr_pos = '0;
			ftype = '0;
			remaining = '0;
			seen = '0;
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// predict the beats caused by one accepted stream byte
		function void note_byte(logic [7:0] b, logic lst);
			logic        have;
			demux_beat_t r;
			have = 1'b0;
			r.payload = b;
			r.ch = 1'b0;
			r.is_st = 1'b0;
			r.st = ST_OK;
			r.eor = !lst;
			if (seen < COUNT_SAT)
				seen++;
			if (!in_pay) begin
				if (hdr_pos == 0) begin
					ftype = b;
					remaining = '0;
				end else if (hdr_pos >= LEN_FIRST) begin
					remaining = {remaining[23:0], b};
				end
				if (hdr_pos == HDR_BYTES - 1) begin
					hdr_pos = '0;
					if (remaining != 0)
						in_pay = 1'b1;
				end else begin
					hdr_pos++;
				end
			end else begin
				if (ftype == TYPE_OUT || ftype == TYPE_ERR) begin
					have = 1'b1;
					r.ch = (ftype == TYPE_ERR);
				end
				remaining--;
				if (remaining == 0)
					in_pay = 1'b0;
			end
			if (have) begin
				expected_beats.push_back(r);
				n_payload++;
			end
			if (lst) begin
				r.payload = '0;
				r.ch = 1'b0;
				r.is_st = 1'b1;
				r.eor = 1'b1;
				// short stream wins over every other end condition
				if (seen <= HDR_BYTES)
					r.st = ST_SHORT;
				else if (!in_pay && hdr_pos != 0)
					r.st = ST_TRUNC;
				else if (in_pay)
					r.st = ST_OVERRUN;
				else
					r.st = ST_OK;
				expected_beats.push_back(r);
				n_status[r.st]++;
				clear_stream();
			end
		endfunction

		function void check_beat(demux_beat_t got);
			demux_beat_t exp_b;
			if (expected_beats.size() == 0) begin
				$display("%0t: unexpected beat payload=%02h ch=%0d", $time,
					got.payload, got.ch);
				$display("%0t: unexpected beat is_status=%0d status=%0d eor=%0d",
					$time, got.is_st, got.st, got.eor);
				errors++;
				return;
			end
			exp_b = expected_beats.pop_front();
			if (got.payload !== exp_b.payload) begin
				$display("%0t: payload_byte expected %02h actual %02h",
					$time, exp_b.payload, got.payload);
				errors++;
			end
			if (got.ch !== exp_b.ch) begin
				$display("%0t: channel expected %0d actual %0d", $time, exp_b.ch, got.ch);
				errors++;
			end
			if (got.is_st !== exp_b.is_st) begin
				$display("%0t: is_status expected %0d actual %0d",
					$time, exp_b.is_st, got.is_st);
				errors++;
			end
			if (got.st !== exp_b.st) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_b.st, got.st);
				errors++;
			end
			if (got.eor !== exp_b.eor) begin
				$display("%0t: end_of_run expected %0d actual %0d",
					$time, exp_b.eor, got.eor);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       data_valid = 1'b0;
	logic       data_ready;
	logic [7:0] data_byte = '0;
	logic       last = 1'b0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [7:0] payload_byte;
	logic       channel;
	logic       is_status;
	logic [1:0] status;
	logic       end_of_run;

	demux_scoreboard sb = new();

	int         tx_idle = 0;
	int         rx_idle = 0;
	int         bytes_sent = 0;
	int         streams_sent = 0;
	logic [7:0] stream_q[$];

	multiplexed_stream_demux dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data_byte(data_byte),
		.last(last),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.payload_byte(payload_byte),
		.channel(channel),
		.is_status(is_status),
		.status(status),
		.end_of_run(end_of_run)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		demux_beat_t got;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				got.payload = payload_byte;
				got.ch = channel;
				got.is_st = is_status;
				got.st = status;
				got.eor = end_of_run;
				sb.check_beat(got);
			end
			if (data_valid && data_ready)
				sb.note_byte(data_byte, last);
		end
	end

	function void push_header(logic [7:0] ftype, logic [31:0] len);
		stream_q.push_back(ftype);
		repeat (3) stream_q.push_back(8'($urandom_range(255)));
		stream_q.push_back(len[31:24]);
		stream_q.push_back(len[23:16]);
		stream_q.push_back(len[15:8]);
		stream_q.push_back(len[7:0]);
	endfunction

	function void push_payload(int n);
		repeat (n) stream_q.push_back(8'($urandom_range(255)));
	endfunction

	task automatic send_byte(logic [7:0] b, logic lst);
		data_valid <= 1'b1;
		data_byte <= b;
		last <= lst;
		@(posedge clk);
		while (!data_ready) @(posedge clk);
		bytes_sent++;
		if ($urandom_range(99) < tx_idle) begin
			data_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
	endtask

	task automatic send_stream();
		for (int i = 0; i < stream_q.size(); i++)
			send_byte(stream_q[i], i == stream_q.size() - 1);
		streams_sent++;
		stream_q.delete();
	endtask

	function logic [7:0] pick_type();
		case ($urandom_range(7))
			0, 1, 2: return TYPE_OUT;
			3, 4, 5: return TYPE_ERR;
			6: return 8'h00;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// mostly well-formed frames, some cut short, some pure noise
	function void build_random_stream();
		int  kind;
		int  nfr;
		bit  done;
		int  len;
		kind = $urandom_range(9);
		done = 1'b0;
		if (kind == 0) begin
			push_payload($urandom_range(24, 1));
			return;
		end
		nfr = $urandom_range(4, 1);
		for (int f = 0; f < nfr && !done; f++) begin
			if ($urandom_range(19) == 0) begin
				// huge length: no frame follows, and the stream ends before this payload is complete
				push_header(pick_type(), $urandom | 32'h0000_0100);
				push_payload($urandom_range(5));
				done = 1'b1;
			end else begin
				len = ($urandom_range(7) == 0) ? 0 : $urandom_range(6, 1);
				push_header(pick_type(), len);
				push_payload(len);
			end
		end
		if (kind <= 3) begin
			len = $urandom_range(stream_q.size() - 1);
			while (stream_q.size() > len + 1)
				stream_q.delete(stream_q.size() - 1);
		end
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both channels, extreme payload values, clean end
		push_header(TYPE_OUT, 32'd1);
		stream_q.push_back(8'h00);
		push_header(TYPE_ERR, 32'd1);
		stream_q.push_back(8'hFF);
		send_stream();
		// single-byte stream
		stream_q.push_back(8'hAA);
		send_stream();
		// zero-length frame, then end right after a header with maximum length
		push_header(8'hFF, 32'd0);
		push_header(TYPE_ERR, 32'hFFFF_FFFF);
		send_stream();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin tx_idle = 32; rx_idle = 87; end
				1: begin tx_idle = 87; rx_idle = 32; end
				default: begin tx_idle = 0; rx_idle = 0; end
			endcase
			while (bytes_sent < 35 + (phase + 1) * 140) begin
				build_random_stream();
				send_stream();
			end
		end
		data_valid <= 1'b0;
		last <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes in %0d streams; checked %0d payload beats.",
			bytes_sent, streams_sent, sb.n_payload);
		$display("End status counts: ok %0d, short %0d, truncated %0d, overrun %0d.",
			sb.n_status[ST_OK], sb.n_status[ST_SHORT], sb.n_status[ST_TRUNC],
			sb.n_status[ST_OVERRUN]);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timeout waiting for the block");
		$display("Mismatches found");
		$finish;
	end

endmodule
